// ----- rtl/core/rrfp_pkg.sv -----
// ----------------------------------------------------------------------------
// rrfp_pkg
// Shared types and constants for the radar report frame parser.
// ----------------------------------------------------------------------------
package rrfp_pkg;

  // Frame delimiters
  localparam logic [7:0] HDR_BYTE0 = 8'hF4;
  localparam logic [7:0] HDR_BYTE1 = 8'hF3;
  localparam logic [7:0] HDR_BYTE2 = 8'hF2;
  localparam logic [7:0] HDR_BYTE3 = 8'hF1;
  localparam logic [7:0] FTR_BYTE0 = 8'hF8;  // footer bytes count down from here

  // Frame layout
  localparam int FRAME_OVERHEAD  = 10;  // header + length + footer
  localparam int FOOTER_BYTES    = 4;
  localparam int POS_LEN_LO      = 4;
  localparam int POS_LEN_HI      = 5;
  localparam int POS_PRESENT     = 6;
  localparam int POS_DIST_LO     = 7;
  localparam int POS_DIST_HI     = 8;
  localparam int POS_GATE_BASE   = 9;
  localparam int REPORT_PAYLOAD  = 35;
  localparam int GATE_COUNT      = 16;
  localparam int GATE_W          = $clog2(GATE_COUNT);
  localparam int GATE_BYTES      = 2 * GATE_COUNT;
  localparam int TOTAL_W         = 17;  // 10 + 16-bit length
  localparam int QUEUE_DEPTH     = 2;
  localparam int QPTR_W          = $clog2(QUEUE_DEPTH);

  // Finished report handed from front to back
  typedef struct packed {
    logic        bank;
    logic        present;
    logic [15:0] distance;
  } cmd_t;

  // Gate energy write into the back-end store
  typedef struct packed {
    logic              en;
    logic              bank;
    logic [GATE_W-1:0] gate;
    logic [15:0]       data;
  } wr_t;

  // Bank release from back to front
  typedef struct packed {
    logic valid;
    logic bank;
  } rel_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_READ,
    BK_SHOW
  } bk_state_t;

endpackage

// ----- rtl/core/rrfp_front.sv -----
// ----------------------------------------------------------------------------
// rrfp_front
// Byte tracker: header hunt, length and footer checks, gate energy capture.
// ----------------------------------------------------------------------------
module rrfp_front #(
  parameter int FRAME_BYTES = 64
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  logic [7:0]     in_rx_byte,
  input  logic           q_full,
  output logic           push,
  output rrfp_pkg::cmd_t push_cmd,
  output rrfp_pkg::wr_t  wr,
  input  rrfp_pkg::rel_t rel
);
  import rrfp_pkg::*;

  localparam int PW = $clog2(FRAME_BYTES);

  logic [PW-1:0] pos_r, pos_nxt;
  logic [15:0]   len_r, len_nxt;
  logic          footer_ok_r, footer_ok_nxt;
  logic          present_r, present_nxt;
  logic [15:0]   dist_r, dist_nxt;
  logic [7:0]    lo_r;
  logic          bank_r, bank_nxt;
  logic [1:0]    busy_r, busy_nxt;

  logic               accept;
  logic [TOTAL_W-1:0] p17, total, total5, ft, gp;
  logic               in_footer, fmatch, footer_ok_now, done, in_gates;
  logic [1:0]         fidx;

  assign in_stall = busy_r[bank_r] | q_full;
  assign accept   = in_valid & ~in_stall;

  always_comb begin
    p17       = TOTAL_W'(pos_r);
    total     = TOTAL_W'(FRAME_OVERHEAD) + TOTAL_W'(len_r);
    total5    = TOTAL_W'(FRAME_OVERHEAD) + TOTAL_W'({in_rx_byte, len_r[7:0]});
    ft        = total - TOTAL_W'(FOOTER_BYTES);
    in_footer = (p17 >= ft);
    fidx      = 2'(p17 - ft);
    fmatch    = (in_rx_byte == (FTR_BYTE0 - {6'd0, fidx}));
    footer_ok_now = footer_ok_r & (~in_footer | fmatch);
    done      = ((p17 + TOTAL_W'(1)) == total);
    gp        = p17 - TOTAL_W'(POS_GATE_BASE);
    in_gates  = (p17 >= TOTAL_W'(POS_GATE_BASE)) &&
                (p17 < TOTAL_W'(POS_GATE_BASE + GATE_BYTES));
  end

  always_comb begin
    pos_nxt       = pos_r;
    len_nxt       = len_r;
    footer_ok_nxt = footer_ok_r;
    present_nxt   = present_r;
    dist_nxt      = dist_r;
    push          = 1'b0;
    if (accept) begin
      if (pos_r == PW'(0)) begin
        if (in_rx_byte == HDR_BYTE0) pos_nxt = PW'(1);
      end else if (pos_r == PW'(1)) begin
        if (in_rx_byte == HDR_BYTE1)      pos_nxt = PW'(2);
        else if (in_rx_byte == HDR_BYTE0) pos_nxt = PW'(1);
        else                              pos_nxt = PW'(0);
      end else if (pos_r == PW'(2)) begin
        pos_nxt = (in_rx_byte == HDR_BYTE2) ? PW'(3) : PW'(0);
      end else if (pos_r == PW'(3)) begin
        pos_nxt = (in_rx_byte == HDR_BYTE3) ? PW'(POS_LEN_LO) : PW'(0);
      end else if (pos_r == PW'(POS_LEN_LO)) begin
        len_nxt[7:0] = in_rx_byte;
        pos_nxt      = PW'(POS_LEN_HI);
      end else if (pos_r == PW'(POS_LEN_HI)) begin
        len_nxt[15:8] = in_rx_byte;
        footer_ok_nxt = 1'b1;
        // oversized frames never get buffered
        pos_nxt = (total5 > TOTAL_W'(FRAME_BYTES)) ? PW'(0) : PW'(POS_PRESENT);
      end else begin
        if (pos_r == PW'(POS_PRESENT)) present_nxt   = (in_rx_byte != 8'd0);
        if (pos_r == PW'(POS_DIST_LO)) dist_nxt[7:0]  = in_rx_byte;
        if (pos_r == PW'(POS_DIST_HI)) dist_nxt[15:8] = in_rx_byte;
        footer_ok_nxt = footer_ok_now;
        if (done) begin
          pos_nxt = PW'(0);
          push    = footer_ok_now && (len_r == 16'(REPORT_PAYLOAD));
        end else begin
          pos_nxt = pos_r + PW'(1);
        end
      end
    end
  end

  always_comb begin
    push_cmd.bank     = bank_r;
    push_cmd.present  = present_r;
    push_cmd.distance = dist_r;
    // odd gate byte completes the word, previous byte held in lo_r
    wr.en   = accept && (pos_r > PW'(POS_LEN_HI)) && in_gates && gp[0];
    wr.bank = bank_r;
    wr.gate = gp[GATE_W:1];
    wr.data = {in_rx_byte, lo_r};
    bank_nxt = push ? ~bank_r : bank_r;
    busy_nxt = busy_r;
    if (rel.valid) busy_nxt[rel.bank] = 1'b0;
    if (push)      busy_nxt[bank_r]   = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      bank_r <= 1'b0;
      busy_r <= '0;
    end else begin
      pos_r  <= pos_nxt;
      bank_r <= bank_nxt;
      busy_r <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    len_r       <= len_nxt;
    footer_ok_r <= footer_ok_nxt;
    present_r   <= present_nxt;
    dist_r      <= dist_nxt;
    if (accept) lo_r <= in_rx_byte;
  end

endmodule

// ----- rtl/core/rrfp_queue.sv -----
// ----------------------------------------------------------------------------
// rrfp_queue
// Short FIFO of finished reports between front and back.
// ----------------------------------------------------------------------------
module rrfp_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  rrfp_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output rrfp_pkg::cmd_t head
);
  import rrfp_pkg::*;

  cmd_t              ent_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [QPTR_W:0]   cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign full    = (cnt_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign empty   = (cnt_r == '0);
  assign head    = ent_r[rp_r];
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;

  always_comb begin
    wp_nxt  = do_push ? wp_r + QPTR_W'(1) : wp_r;
    rp_nxt  = do_pop ? rp_r + QPTR_W'(1) : rp_r;
    cnt_nxt = cnt_r + (QPTR_W+1)'(do_push) - (QPTR_W+1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) ent_r[wp_r] <= push_cmd;
  end

endmodule

// ----- rtl/core/rrfp_back.sv -----
// ----------------------------------------------------------------------------
// rrfp_back
// Gate energy store and result sequencer: one result per gate.
// ----------------------------------------------------------------------------
module rrfp_back (
  input  logic           clk,
  input  logic           rst_n,
  input  rrfp_pkg::wr_t  wr,
  input  logic           q_empty,
  input  rrfp_pkg::cmd_t q_head,
  output logic           q_pop,
  output rrfp_pkg::rel_t rel,
  output logic           out_valid,
  input  logic           out_stall,
  output logic           out_target_present,
  output logic [15:0]    out_distance_cm,
  output logic [3:0]     out_gate_index,
  output logic [15:0]    out_gate_energy,
  output logic           out_last_gate
);
  import rrfp_pkg::*;

  logic [15:0] mem [2*GATE_COUNT];
  logic [15:0] rd_data_r;

  bk_state_t         state_r, state_nxt;
  cmd_t              cmd_r;
  logic [GATE_W-1:0] gate_r, gate_nxt;
  logic              rd_en, is_last;

  assign is_last = (gate_r == GATE_W'(GATE_COUNT - 1));

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: if (!q_empty) state_nxt = BK_READ;
      BK_READ: state_nxt = BK_SHOW;
      BK_SHOW: begin
        if (!out_stall) state_nxt = is_last ? BK_IDLE : BK_READ;
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    q_pop     = 1'b0;
    rd_en     = 1'b0;
    out_valid = 1'b0;
    rel.valid = 1'b0;
    rel.bank  = cmd_r.bank;
    gate_nxt  = gate_r;
    unique case (state_r)
      BK_IDLE: begin
        q_pop    = ~q_empty;
        gate_nxt = '0;
      end
      BK_READ: rd_en = 1'b1;
      BK_SHOW: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          rel.valid = is_last;
          gate_nxt  = gate_r + GATE_W'(1);
        end
      end
      default: ;
    endcase
  end

  assign out_target_present = cmd_r.present;
  assign out_distance_cm    = cmd_r.distance;
  assign out_gate_index     = 4'(gate_r);
  assign out_gate_energy    = rd_data_r;
  assign out_last_gate      = is_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    gate_r <= gate_nxt;
    if (q_pop) cmd_r <= q_head;
  end

  always_ff @(posedge clk) begin
    if (wr.en) mem[{wr.bank, wr.gate}] <= wr.data;
    if (rd_en) rd_data_r <= mem[{cmd_r.bank, gate_r}];
  end

endmodule

// ----- rtl/core/radar_report_frame_parser.sv -----
// ----------------------------------------------------------------------------
// radar_report_frame_parser
// Byte-stream frame parser emitting one result per range gate.
// ----------------------------------------------------------------------------
// Takes one byte per cycle while not stalled. A frame with a good header,
// length and footer whose payload is 35 bytes yields 16 results. The back end
// pops the report from the queue, then for each result reads the store and
// then shows the value from the output register. Gate energies are
// double-banked: the next frame is taken while the previous report drains,
// and the input stalls only when both banks still hold undelivered reports.
module radar_report_frame_parser #(
  parameter int FRAME_BYTES = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_target_present,
  output logic [15:0] out_distance_cm,
  output logic [3:0]  out_gate_index,
  output logic [15:0] out_gate_energy,
  output logic        out_last_gate
);
  import rrfp_pkg::*;

  logic q_full, q_empty, push, q_pop;
  cmd_t push_cmd, q_head;
  wr_t  wr;
  rel_t rel;

  rrfp_front #(
    .FRAME_BYTES(FRAME_BYTES)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_rx_byte (in_rx_byte),
    .q_full     (q_full),
    .push       (push),
    .push_cmd   (push_cmd),
    .wr         (wr),
    .rel        (rel)
  );

  rrfp_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .head     (q_head)
  );

  rrfp_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .wr                 (wr),
    .q_empty            (q_empty),
    .q_head             (q_head),
    .q_pop              (q_pop),
    .rel                (rel),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_target_present (out_target_present),
    .out_distance_cm    (out_distance_cm),
    .out_gate_index     (out_gate_index),
    .out_gate_energy    (out_gate_energy),
    .out_last_gate      (out_last_gate)
  );

endmodule

// ----- verif/tb_radar_report_frame_parser.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_radar_report_frame_parser
// Self-checking bench for the radar report frame parser. Byte streams made of
// good reports, other-length frames, broken headers, bad footers, oversize
// lengths and noise are sent with random gaps and output stalls. Each accepted
// byte runs through a local frame parser that queues the gate results it
// expects; every output transfer is checked field by field against the queue.
// ----------------------------------------------------------------------------
module tb_radar_report_frame_parser;
  import rrfp_pkg::*;

  localparam int FRAME_LEN = 64;
  localparam int FOOTER_OK = -1;
  localparam int MAX_PRINTS = 40;

  typedef struct {
    logic        present;
    logic [15:0] distance;
    logic [3:0]  gate;
    logic [15:0] energy;
    logic        last;
  } gate_result_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_rx_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_target_present;
  logic [15:0] out_distance_cm;
  logic [3:0]  out_gate_index;
  logic [15:0] out_gate_energy;
  logic        out_last_gate;

  // parser model state
  int          frame_pos;
  logic [7:0]  frame_buf [FRAME_LEN];
  gate_result_t expected_gates [$];

  logic [7:0]  tx_bytes [$];
  int          send_idle_pct;
  int          recv_stall_pct;
  logic        hold_active = 1'b0;
  int          mismatches;

  radar_report_frame_parser #(.FRAME_BYTES(FRAME_LEN)) dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_rx_byte         (in_rx_byte),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_target_present (out_target_present),
    .out_distance_cm    (out_distance_cm),
    .out_gate_index     (out_gate_index),
    .out_gate_energy    (out_gate_energy),
    .out_last_gate      (out_last_gate)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("Regression FAIL");
    $finish;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    if (mismatches < MAX_PRINTS) begin
      $display("ERROR @%0t: %s: got %0h, expected %0h", $time, what, got, want);
    end
    mismatches++;
  endtask

  // Advance the frame model by one accepted byte, queueing any gate results.
  function automatic void parse_rx_byte(input logic [7:0] b);
    int plen;
    int total;
    gate_result_t r;
    if (frame_pos == 0 && b != HDR_BYTE0) return;
    if (frame_pos == 1 && b != HDR_BYTE1) begin
      frame_pos = (b == HDR_BYTE0) ? 1 : 0;
      return;
    end
    if ((frame_pos == 2 && b != HDR_BYTE2) || (frame_pos == 3 && b != HDR_BYTE3) ||
        frame_pos >= FRAME_LEN) begin
      frame_pos = 0;
      return;
    end
    frame_buf[frame_pos] = b;
    frame_pos++;
    if (frame_pos <= POS_LEN_HI) return;
    plen = {frame_buf[POS_LEN_HI], frame_buf[POS_LEN_LO]};
    total = FRAME_OVERHEAD + plen;
    if (total > FRAME_LEN) begin
      frame_pos = 0;
      return;
    end
    if (frame_pos < total) return;
    frame_pos = 0;
    for (int k = 0; k < FOOTER_BYTES; k++) begin
      if (frame_buf[total - FOOTER_BYTES + k] != FTR_BYTE0 - 8'(k)) return;
    end
    if (plen != REPORT_PAYLOAD) return;
    for (int g = 0; g < GATE_COUNT; g++) begin
      r.present  = (frame_buf[POS_PRESENT] != 8'h00);
      r.distance = {frame_buf[POS_DIST_HI], frame_buf[POS_DIST_LO]};
      r.gate     = 4'(g);
      r.energy   = {frame_buf[POS_GATE_BASE + 2*g + 1], frame_buf[POS_GATE_BASE + 2*g]};
      r.last     = (g == GATE_COUNT - 1);
      expected_gates.push_back(r);
    end
  endfunction

  task automatic send_rx_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    parse_rx_byte(b);
  endtask

  task automatic transmit_queued();
    while (tx_bytes.size() != 0) send_rx_byte(tx_bytes.pop_front());
  endtask

  // Pad with zeros until the parser is back to hunting for a header.
  task automatic settle_parser();
    while (frame_pos != 0) send_rx_byte(8'h00);
  endtask

  task automatic queue_header(input logic [15:0] plen);
    tx_bytes.push_back(HDR_BYTE0);
    tx_bytes.push_back(HDR_BYTE1);
    tx_bytes.push_back(HDR_BYTE2);
    tx_bytes.push_back(HDR_BYTE3);
    tx_bytes.push_back(plen[7:0]);
    tx_bytes.push_back(plen[15:8]);
  endtask

  task automatic queue_footer(input int bad_pos);
    logic [7:0] fb;
    for (int k = 0; k < FOOTER_BYTES; k++) begin
      fb = FTR_BYTE0 - 8'(k);
      if (k == bad_pos) fb ^= 8'($urandom_range(255, 1));
      tx_bytes.push_back(fb);
    end
  endtask

  task automatic send_report(input logic [7:0] present, input logic [15:0] dist_cm,
                             input logic [15:0] fill, input bit rand_energy,
                             input int bad_pos);
    logic [15:0] e;
    settle_parser();
    queue_header(16'(REPORT_PAYLOAD));
    tx_bytes.push_back(present);
    tx_bytes.push_back(dist_cm[7:0]);
    tx_bytes.push_back(dist_cm[15:8]);
    for (int g = 0; g < GATE_COUNT; g++) begin
      e = rand_energy ? 16'($urandom_range(65535)) : fill;
      tx_bytes.push_back(e[7:0]);
      tx_bytes.push_back(e[15:8]);
    end
    queue_footer(bad_pos);
    transmit_queued();
  endtask

  // Frame with a random payload of the given length; oversize lengths stop
  // after the length field since the parser drops them there.
  task automatic send_plain_frame(input int plen, input int bad_pos);
    settle_parser();
    queue_header(16'(plen));
    if (FRAME_OVERHEAD + plen <= FRAME_LEN) begin
      repeat (plen) tx_bytes.push_back(8'($urandom_range(255)));
      queue_footer(bad_pos);
    end
    transmit_queued();
  endtask

  task automatic send_random_report(input int bad_pos);
    logic [7:0] present;
    present = ($urandom_range(3) == 0) ? 8'h00 : 8'($urandom_range(255));
    send_report(present, 16'($urandom_range(65535)), 16'h0000, 1'b1, bad_pos);
  endtask

  task automatic set_idling(input int send_pct, input int recv_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  task automatic hold_receiver(input int cycles);
    hold_active <= 1'b1;
    repeat (cycles) @(posedge clk);
    hold_active <= 1'b0;
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_header_hunt();
    // stray bytes, then F4 repeated at header position 1 restarts the hunt
    tx_bytes = '{8'h00, 8'hFF, HDR_BYTE1, HDR_BYTE0, HDR_BYTE0};
    transmit_queued();
    queue_header(16'(REPORT_PAYLOAD));
    void'(tx_bytes.pop_front());
    transmit_queued();
    repeat (REPORT_PAYLOAD) send_rx_byte(8'($urandom_range(255)));
    queue_footer(FOOTER_OK);
    transmit_queued();
    // wrong second, third and fourth header bytes
    tx_bytes = '{HDR_BYTE0, 8'h55, HDR_BYTE0, HDR_BYTE1, 8'h00,
                 HDR_BYTE0, HDR_BYTE1, HDR_BYTE2, HDR_BYTE0};
    transmit_queued();
    send_random_report(FOOTER_OK);
  endtask

  task automatic test_report_extremes();
    send_report(8'h00, 16'h0000, 16'h0000, 1'b0, FOOTER_OK);
    send_report(8'hFF, 16'hFFFF, 16'hFFFF, 1'b0, FOOTER_OK);
    send_report(8'h01, 16'h8001, 16'h0000, 1'b1, FOOTER_OK);
  endtask

  task automatic test_rejected_frames();
    send_plain_frame(FRAME_LEN - FRAME_OVERHEAD + 1, FOOTER_OK);
    send_plain_frame(16'hFFFF, FOOTER_OK);
    send_plain_frame(16'h0100, FOOTER_OK);
    for (int k = 0; k < FOOTER_BYTES; k++) send_random_report(k);
  endtask

  task automatic test_other_lengths();
    send_plain_frame(0, FOOTER_OK);
    send_plain_frame(REPORT_PAYLOAD - 1, FOOTER_OK);
    send_plain_frame(REPORT_PAYLOAD + 1, FOOTER_OK);
    send_plain_frame(FRAME_LEN - FRAME_OVERHEAD, FOOTER_OK);
    send_random_report(FOOTER_OK);
  endtask

  task automatic test_random_traffic(input int sequences);
    int pick;
    int plen;
    int n;
    repeat (sequences) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        send_random_report(FOOTER_OK);
      end else if (pick < 70) begin
        do plen = $urandom_range(FRAME_LEN - FRAME_OVERHEAD); while (plen == REPORT_PAYLOAD);
        send_plain_frame(plen, FOOTER_OK);
      end else if (pick < 78) begin
        send_random_report($urandom_range(FOOTER_BYTES - 1));
      end else if (pick < 86) begin
        send_plain_frame($urandom_range(65535, FRAME_LEN - FRAME_OVERHEAD + 1), FOOTER_OK);
      end else if (pick < 93) begin
        settle_parser();
        queue_header(16'(REPORT_PAYLOAD));
        n = $urandom_range(3, 1);
        while (tx_bytes.size() > n) void'(tx_bytes.pop_back());
        tx_bytes.push_back(8'($urandom_range(255)));
        transmit_queued();
      end else begin
        repeat ($urandom_range(8, 1)) begin
          send_rx_byte(($urandom_range(2) == 0) ? HDR_BYTE0 : 8'($urandom_range(255)));
        end
      end
    end
  endtask

  // Receiver holds off while reports keep coming, so both banks fill and the
  // input side has to stall.
  task automatic test_backpressure();
    set_idling(0, 0);
    fork
      hold_receiver(400);
    join_none
    repeat (4) send_random_report(FOOTER_OK);
  endtask

  // ---------------------------------------------------------------- checker

  always @(posedge clk) begin
    gate_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_gates.size() == 0) begin
        report_mismatch("unexpected result, gate", out_gate_index, 0);
      end else begin
        want = expected_gates.pop_front();
        if (out_target_present != want.present)
          report_mismatch("target_present", out_target_present, want.present);
        if (out_distance_cm != want.distance)
          report_mismatch("distance_cm", out_distance_cm, want.distance);
        if (out_gate_index != want.gate)
          report_mismatch("gate_index", out_gate_index, want.gate);
        if (out_gate_energy != want.energy)
          report_mismatch("gate_energy", out_gate_energy, want.energy);
        if (out_last_gate != want.last)
          report_mismatch("last_gate", out_last_gate, want.last);
      end
    end
    out_stall <= hold_active || ($urandom_range(99) < recv_stall_pct);
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    mismatches = 0;
    frame_pos  = 0;
    set_idling(25, 54);
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_header_hunt();
    test_report_extremes();
    test_rejected_frames();
    test_other_lengths();
    test_random_traffic(6);
    set_idling(54, 25);
    test_random_traffic(6);
    set_idling(0, 0);
    test_random_traffic(6);
    test_backpressure();

    in_valid <= 1'b0;
    while (expected_gates.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/rrfp_pkg.sv
rtl/core/rrfp_front.sv
rtl/core/rrfp_queue.sv
rtl/core/rrfp_back.sv
rtl/core/radar_report_frame_parser.sv
verif/tb_radar_report_frame_parser.sv
